// File: rtl/bbp_pkg.sv
// Shared types, constants and codes for the best-fit bin packer.
// No dependencies; bbp_scan and the top level import this package, bbp_ram does not.
package bbp_pkg;

    localparam int MAX_BINS = 64;
    localparam int BIN_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W    = $clog2(MAX_BINS + 1);

    localparam int CAP_W   = 10;
    localparam int ID_W    = 16;
    localparam int OBIN_W  = 6;
    localparam int OCNT_W  = 7;
    localparam int ST_W    = 2;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERSIZE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CAP_W-1:0] size;
        logic [CNT_W-1:0] count;
    } t_scan_req;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [BIN_W-1:0] idx;
        logic [CAP_W-1:0] orig;
    } t_scan_res;

endpackage

// File: rtl/bbp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used for the per-bin leftover store.
module bbp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bbp_scan.sv
// Best-fit search over the open bins, one read of the leftover store per bin.
// Depends on bbp_pkg; drives the read port of the leftover RAM.
module bbp_scan
    import bbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_req        i_req,
    output t_scan_res        o_res,
    output logic             o_rd_en,
    output logic [BIN_W-1:0] o_rd_addr,
    input  logic [CAP_W-1:0] i_rd_data
);

    logic             r_busy;
    logic [CNT_W-1:0] r_issue_idx;
    logic [CNT_W-1:0] r_count;
    logic [CAP_W-1:0] r_size;
    logic             r_cmp_v;
    logic [BIN_W-1:0] r_cmp_idx;
    logic             r_found;
    logic [BIN_W-1:0] r_best_idx;
    logic [CAP_W-1:0] r_best_rem;
    logic [CAP_W-1:0] r_best_orig;

    logic             w_issue;
    logic             w_done;
    logic             w_fit;
    logic [CAP_W-1:0] w_rem;
    logic             w_better;

    always_comb begin
        w_issue  = r_busy && (r_issue_idx < r_count);
        w_done   = r_busy && !w_issue && !r_cmp_v;
        w_fit    = i_rd_data >= r_size;
        w_rem    = i_rd_data - r_size;
        w_better = w_fit && (!r_found || (w_rem < r_best_rem));
    end

    assign o_rd_en   = w_issue;
    assign o_rd_addr = r_issue_idx[BIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_issue_idx <= '0;
            r_count     <= '0;
            r_cmp_v     <= 1'b0;
            r_found     <= 1'b0;
        end else if (i_req.start) begin
            r_busy      <= 1'b1;
            r_issue_idx <= '0;
            r_count     <= i_req.count;
            r_size      <= i_req.size;
            r_cmp_v     <= 1'b0;
            r_found     <= 1'b0;
        end else if (r_busy) begin
            if (w_issue) begin
                r_issue_idx <= r_issue_idx + CNT_W'(1);
                r_cmp_v     <= 1'b1;
                r_cmp_idx   <= r_issue_idx[BIN_W-1:0];
            end else begin
                r_cmp_v <= 1'b0;
            end
            // Read data of the entry issued last cycle is valid now.
            if (r_cmp_v && w_better) begin
                r_found     <= 1'b1;
                r_best_idx  <= r_cmp_idx;
                r_best_rem  <= w_rem;
                r_best_orig <= i_rd_data;
            end
            if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_res.done  = w_done;
    assign o_res.found = r_found;
    assign o_res.idx   = r_best_idx;
    assign o_res.orig  = r_best_orig;

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue_idx <= r_count)
        else $error("scan issued a read beyond the open bins");

    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !r_busy) |-> ((r_best_orig >= r_size) && (CNT_W'(r_best_idx) < r_count)))
        else $error("chosen bin does not hold the task or is not open");

endmodule

// File: rtl/best_fit_bin_packer.sv
// Top level of the best-fit bin packer: request control, bin count, result register.
// Depends on bbp_pkg, bbp_ram and bbp_scan.
//
//  channel   direction  handshake                 contents
//  s_axis    in         tvalid/tready             tuser: op; tdata: task_id, task_size
//  m_axis    out        tvalid/tready             tuser: status; tdata: result fields
//  cfg       in         i_cfg_we (no wait)        capacity
//
// A place request searches the leftover store, reading it once per open bin through its
// single read port. Clear and oversized requests go to the final step with no search.
// A new request is taken while the previous result still waits in the output register;
// a stalled output holds the block in its final step. Reset is synchronous; the leftover
// store needs no clearing.
module best_fit_bin_packer
    import bbp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [15:0] task_id, [25:16] task_size, [31:26] zero
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // [0] op
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [15:0] echo_id, [21:16] bin_index, [31:22] first_slot, [32] opened_new,
    // [39:33] bins_used
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [ST_W-1:0]     m_axis_tuser,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata
);

    t_state           r_state, n_state;
    logic [CAP_W-1:0] r_capacity;
    logic [CNT_W-1:0] r_open_count;
    logic             r_op;
    logic             r_oversize;
    logic [ID_W-1:0]  r_id;
    logic [CAP_W-1:0] r_size;

    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic [ST_W-1:0]     r_out_user;

    t_scan_req        w_req;
    t_scan_res        w_res;
    logic             w_rd_en;
    logic [BIN_W-1:0] w_rd_addr;
    logic [CAP_W-1:0] w_rd_data;

    logic             w_accept;
    logic [ID_W-1:0]  w_in_id;
    logic [CAP_W-1:0] w_in_size;
    logic             w_in_over;
    logic             w_load;

    logic             w_we;
    logic [BIN_W-1:0] w_waddr;
    logic [CAP_W-1:0] w_wdata;
    logic [BIN_W-1:0] w_bin;
    logic [CAP_W-1:0] w_slot;
    logic             w_new;
    logic [ST_W-1:0]  w_status;
    logic [CNT_W-1:0] w_count_next;

    assign w_in_id   = s_axis_tdata[ID_W-1:0];
    assign w_in_size = s_axis_tdata[ID_W+CAP_W-1:ID_W];
    assign w_in_over = w_in_size > r_capacity;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    assign w_req.start = w_accept && (s_axis_tuser == OP_PLACE) && !w_in_over;
    assign w_req.size  = w_in_size;
    assign w_req.count = r_open_count;

    bbp_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_res     (w_res),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

    bbp_ram #(
        .WIDTH (CAP_W),
        .DEPTH (MAX_BINS)
    ) u_leftover (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_req.start ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (w_res.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outcome of the request; the RAM write and count update happen only when
    // the result is loaded, so a stalled output never repeats them.
    always_comb begin
        w_we         = 1'b0;
        w_waddr      = r_open_count[BIN_W-1:0];
        w_wdata      = r_capacity - r_size;
        w_bin        = '0;
        w_slot       = '0;
        w_new        = 1'b0;
        w_status     = ST_OK;
        w_count_next = r_open_count;
        priority if (r_op == OP_CLEAR) begin
            w_count_next = '0;
        end else if (r_oversize) begin
            w_status = ST_OVERSIZE;
        end else if (w_res.found) begin
            w_we    = w_load;
            w_waddr = w_res.idx;
            w_wdata = w_res.orig - r_size;
            w_bin   = w_res.idx;
            w_slot  = r_capacity - w_res.orig;
        end else if (r_open_count < CNT_W'(MAX_BINS)) begin
            w_we         = w_load;
            w_bin        = r_open_count[BIN_W-1:0];
            w_new        = 1'b1;
            w_count_next = r_open_count + CNT_W'(1);
        end else begin
            w_status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_capacity   <= CAP_RESET;
            r_open_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (w_load) begin
                r_open_count <= w_count_next;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= s_axis_tuser;
            r_oversize <= w_in_over;
            r_id       <= w_in_id;
            r_size     <= w_in_size;
        end
        if (w_load) begin
            r_out_data <= {OCNT_W'(w_count_next), w_new, w_slot, OBIN_W'(w_bin), r_id};
            r_out_user <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_count <= CNT_W'(MAX_BINS))
        else $error("open bin count beyond the bin store");

    a_new_bin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_new) |=> (r_open_count == $past(r_open_count) + CNT_W'(1)))
        else $error("new bin opened without a count increment");

    a_write_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_out_valid && (r_out_user == ST_OK)))
        else $error("bin store written without a placed result");

endmodule
